// ===== rtl/core/prdp_pkg.sv =====
// Package for the planar RLE/delta plane decoder: sizes, beat structs,
// sequencer states, register indexes and the raw-byte delta decode.
// No dependencies.
package prdp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CFG_W  = 13;
    localparam int CNT_W  = 24;
    localparam int NPIX_W = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] CFG_RST_WIDTH  = 13'd64;
    localparam logic [CFG_W-1:0] CFG_RST_HEIGHT = 13'd64;
    localparam logic [CFG_W-1:0] EFF_MAX_WIDTH  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] EFF_MAX_HEIGHT = CFG_W'(MAX_HEIGHT);

    // long-run form of a control byte: nibble-swapped value in this range
    localparam logic [7:0] LONG_RUN_MIN = 8'd16;
    localparam logic [7:0] LONG_RUN_MAX = 8'd47;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    typedef struct packed {
        logic [7:0] code_byte;
        logic       start_plane;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic        last_of_run;
        logic        plane_done;
        logic        row_overrun;
        logic [23:0] bytes_consumed;
    } t_out_beat;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // operands of the shared pixel unit
    typedef struct packed {
        logic [7:0] above;
        logic [7:0] colour;
        logic       first_row;
    } t_pix_req;

    // raw byte: literal on the first row, else LSB-sign delta
    // (even v: +v/2, odd v: -(v/2 + 1))
    function automatic logic [7:0] delta_decode(input logic [7:0] b,
                                                input logic       first_row);
        logic [7:0] res;
        if (first_row) begin
            res = b;
        end else if (b[0]) begin
            res = {1'b1, ~b[7:1]};
        end else begin
            res = {1'b0, b[7:1]};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/prdp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/prdp_pix_unit.sv =====
// Shared pixel unit: first row passes the colour, later rows add the
// delta to the pixel above, modulo 256. Uses prdp_pkg.
module prdp_pix_unit
    import prdp_pkg::*;
(
    input  t_pix_req   i_req,
    output logic [7:0] o_value
);

    always_comb begin
        if (i_req.first_row) begin
            o_value = i_req.colour;
        end else begin
            o_value = i_req.above + i_req.colour;
        end
    end

endmodule

// ===== rtl/core/planar_rle_delta_plane_decoder.sv =====
// Planar RLE/delta plane decoder, top level. Uses prdp_pkg, prdp_ram, prdp_pix_unit.
// Flow: an accepted byte that stores P > 0 pixels (P in 0..47) sends the
//   sequencer to the emit state, and no new byte is taken until its last
//   pixel is out. Pixels go out one per cycle while the output is not stalled,
//   paced by the line buffer read-modify-write through the single pixel adder.
// Reset: synchronous, active low; clears sequencer, counters and registers
//   (width/height back to 64). The line buffer is not cleared.
module planar_rle_delta_plane_decoder
    import prdp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // code byte channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    // pixel channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg_width, r_cfg_height;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [3:0]         r_raw, n_raw;       // raw bytes still expected
    logic [3:0]         r_pend, n_pend;     // run queued behind the raw bytes
    logic [7:0]         r_colour, n_colour; // colour (first row) or delta
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovr, n_ovr;
    logic [NPIX_W-1:0]  r_left, n_left;     // pixels still to emit for this byte
    logic               r_out_valid;
    t_out_beat          r_out;

    // ------------------------------------------------------------------
    // effective plane size: zero reads as 1, clamp to the buffer size
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] w_eff, h_eff;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CFG_W'(1);
        end else if (r_cfg_width > EFF_MAX_WIDTH) begin
            w_eff = EFF_MAX_WIDTH;
        end else begin
            w_eff = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (r_cfg_height > EFF_MAX_HEIGHT) begin
            h_eff = EFF_MAX_HEIGHT;
        end else begin
            h_eff = r_cfg_height;
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state and control outputs
    // ------------------------------------------------------------------
    logic w_accept, w_fire, w_out_free, w_ignore;
    logic [NPIX_W-1:0] d_npix_kept;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !w_ignore && d_npix_kept != '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free && r_left == NPIX_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_fire     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
            end
            ST_EMIT: begin
                w_fire = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // byte decode: state after this byte, as if it were accepted now
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  s_col, d_col;
    logic [ROW_W-1:0]  s_row, d_row;
    logic [3:0]        s_raw, d_raw, s_pend, d_pend;
    logic [7:0]        s_colour, d_colour;
    logic [CNT_W-1:0]  s_cnt, d_cnt;
    logic              s_ovr, d_ovr;
    logic [NPIX_W-1:0] d_npix;
    logic [CFG_W-1:0]  d_avail;
    logic [3:0]        lo, hi;
    logic [7:0]        rev;

    always_comb begin
        // start of plane clears position and stream state first
        if (i_in_data.start_plane) begin
            s_col    = '0;
            s_row    = '0;
            s_raw    = '0;
            s_pend   = '0;
            s_colour = '0;
            s_cnt    = '0;
            s_ovr    = 1'b0;
        end else begin
            s_col    = r_col;
            s_row    = r_row;
            s_raw    = r_raw;
            s_pend   = r_pend;
            s_colour = r_colour;
            s_cnt    = r_cnt;
            s_ovr    = r_ovr;
        end

        lo  = i_in_data.code_byte[3:0];
        hi  = i_in_data.code_byte[7:4];
        rev = {lo, hi};

        d_col    = s_col;
        d_row    = s_row;
        d_raw    = s_raw;
        d_pend   = s_pend;
        d_colour = s_colour;
        d_npix   = '0;
        w_ignore = 1'b0;

        if (s_raw != '0) begin
            // raw byte: one pixel, then the queued run after the last raw byte
            d_colour = delta_decode(i_in_data.code_byte, s_row == '0);
            d_raw    = s_raw - 4'd1;
            if (d_raw == '0) begin
                d_npix = NPIX_W'(1) + NPIX_W'(s_pend);
                d_pend = '0;
            end else begin
                d_npix = NPIX_W'(1);
            end
        end else begin
            // control byte; row advances only here
            if (CFG_W'(s_col) >= w_eff) begin
                if (CFG_W'(s_row) + CFG_W'(1) >= h_eff) begin
                    w_ignore = 1'b1;  // plane finished
                end else begin
                    d_row    = s_row + ROW_W'(1);
                    d_col    = '0;
                    d_colour = '0;
                end
            end
            if (rev >= LONG_RUN_MIN && rev <= LONG_RUN_MAX) begin
                d_npix = NPIX_W'(rev);
            end else if (hi == '0) begin
                d_npix = NPIX_W'(lo);
            end else begin
                d_raw  = hi;
                d_pend = lo;
            end
        end

        // pixels past the row end are dropped and flag the overrun
        if (CFG_W'(d_col) < w_eff) begin
            d_avail = w_eff - CFG_W'(d_col);
        end else begin
            d_avail = '0;
        end
        if (CFG_W'(d_npix) > d_avail) begin
            d_npix_kept = NPIX_W'(d_avail);
            d_ovr       = 1'b1;
        end else begin
            d_npix_kept = d_npix;
            d_ovr       = s_ovr;
        end

        d_cnt = (s_cnt == CNT_SAT) ? s_cnt : s_cnt + CNT_W'(1);
    end

    // ------------------------------------------------------------------
    // next register values
    // ------------------------------------------------------------------
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_raw    = r_raw;
        n_pend   = r_pend;
        n_colour = r_colour;
        n_cnt    = r_cnt;
        n_ovr    = r_ovr;
        n_left   = r_left;
        if (w_accept && !w_ignore) begin
            n_col    = d_col;
            n_row    = d_row;
            n_raw    = d_raw;
            n_pend   = d_pend;
            n_colour = d_colour;
            n_cnt    = d_cnt;
            n_ovr    = d_ovr;
            n_left   = d_npix_kept;
        end else if (w_fire) begin
            n_col  = r_col + COL_W'(1);
            n_left = r_left - NPIX_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // line buffer and pixel unit
    // The read address follows the next column, so the pixel above is
    // waiting in the read register whenever a pixel goes out.
    // ------------------------------------------------------------------
    logic [7:0] w_above, w_pix;
    t_pix_req   w_req;

    prdp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_col[ADDR_W-1:0]),
        .i_wdata (w_pix),
        .i_raddr (n_col[ADDR_W-1:0]),
        .o_rdata (w_above)
    );

    assign w_req.above     = w_above;
    assign w_req.colour    = r_colour;
    assign w_req.first_row = (r_row == '0);

    prdp_pix_unit u_pix (
        .i_req   (w_req),
        .o_value (w_pix)
    );

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_RST_WIDTH;
            r_cfg_height <= CFG_RST_HEIGHT;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_WIDTH) begin
                r_cfg_width <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_HEIGHT) begin
                r_cfg_height <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_raw       <= '0;
            r_pend      <= '0;
            r_colour    <= '0;
            r_cnt       <= '0;
            r_ovr       <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_raw    <= n_raw;
            r_pend   <= n_pend;
            r_colour <= n_colour;
            r_cnt    <= n_cnt;
            r_ovr    <= n_ovr;
            r_left   <= n_left;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.pixel_value    <= w_pix;
            r_out.pixel_column   <= 12'(r_col);
            r_out.pixel_row      <= 12'(r_row);
            r_out.last_of_run    <= (r_left == NPIX_W'(1));
            r_out.plane_done     <= (CFG_W'(r_row) + CFG_W'(1) == h_eff) &&
                                    (CFG_W'(r_col) + CFG_W'(1) == w_eff);
            r_out.row_overrun    <= r_ovr;
            r_out.bytes_consumed <= r_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the byte's last pixel returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_left == NPIX_W'(1)) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after last pixel");

    // while emitting there is always a pixel left to send
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0))
        else $error("emit state with no pixels left");

    // dropped pixels are trimmed at accept, so emitted columns stay in the row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (CFG_W'(r_col) < w_eff))
        else $error("emitting a pixel past the row width");

    // a pixel beat is loaded only from the emit state
    a_fire_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("pixel beat produced outside the emit state");

endmodule
